>>> sv/acfe_pkg.sv
// ----------------------------------------------------------------------------
// acfe_pkg
// Shared constants, register map and types of the arm command frame encoder.
// ----------------------------------------------------------------------------
package acfe_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned WordW    = 32;
  localparam int unsigned MantW    = 23;
  localparam int unsigned PosW     = 5;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned AddrW    = 5;

  localparam logic [7:0]        StartByte = 8'hA5;
  localparam logic [7:0]        EndByte   = 8'h5A;
  localparam logic [7:0]        ExpBias   = 8'd127;
  localparam logic [CoordW-1:0] MagLimit  = 24'd8388607;
  localparam logic [IdxW-1:0]   LastIdx   = 6'd41;

  localparam logic [WordW-1:0] ModeReset       = 32'h4040_0000;
  localparam logic [WordW-1:0] MotionKindReset = 32'h3F80_0000;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_RESERVED    = 3'd1,
    REG_ROTATION    = 3'd2,
    REG_SUCTION     = 3'd3,
    REG_MOTION_KIND = 3'd4,
    REG_GRIPPER     = 3'd5,
    REG_PAUSE       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [WordW-1:0] mode;
    logic [WordW-1:0] reserved;
    logic [WordW-1:0] rotation;
    logic [WordW-1:0] suction;
    logic [WordW-1:0] motion_kind;
    logic [WordW-1:0] gripper;
    logic [WordW-1:0] pause;
  } cfg_words_t;

  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
  } coord_words_t;

  function automatic logic [PosW-1:0] lead_one_pos(input logic [MantW-1:0] mag);
    logic [PosW-1:0] pos;
    pos = '0;
    for (int b = 0; b < MantW; b++) begin
      if (mag[b]) begin
        pos = PosW'(b);
      end
    end
    return pos;
  endfunction

endpackage

>>> sv/acfe_lane.sv
// ----------------------------------------------------------------------------
// acfe_lane
// Converts one signed 24-bit coordinate into a single-precision word, registered.
// ----------------------------------------------------------------------------
module acfe_lane (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic signed [acfe_pkg::CoordW-1:0] coord_i,
  output logic [acfe_pkg::WordW-1:0]       word_o
);

  logic                            neg;
  logic [acfe_pkg::CoordW-1:0]     mag_full;
  logic [acfe_pkg::MantW-1:0]      mag;
  logic [acfe_pkg::PosW-1:0]       pos;
  logic [acfe_pkg::PosW-1:0]       shamt;
  logic [acfe_pkg::CoordW-1:0]     shifted;
  logic [7:0]                      expo;
  logic [acfe_pkg::WordW-1:0]      word_d;
  logic [acfe_pkg::WordW-1:0]      word_q;

  always_comb begin
    neg      = coord_i[acfe_pkg::CoordW-1];
    mag_full = neg ? (~coord_i + 1'b1) : coord_i;
    if (mag_full > acfe_pkg::MagLimit) begin
      mag = acfe_pkg::MagLimit[acfe_pkg::MantW-1:0];
    end else begin
      mag = mag_full[acfe_pkg::MantW-1:0];
    end
    pos     = acfe_pkg::lead_one_pos(mag);
    shamt   = 5'd23 - pos;
    shifted = {1'b0, mag} << shamt;
    expo    = acfe_pkg::ExpBias + {3'b000, pos};
    if (mag == '0) begin
      word_d = '0;
    end else begin
      word_d = {neg, expo, shifted[acfe_pkg::MantW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

>>> sv/acfe_cfg_regs.sv
// ----------------------------------------------------------------------------
// acfe_cfg_regs
// APB register file holding the seven fixed frame words.
// ----------------------------------------------------------------------------
module acfe_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acfe_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output acfe_pkg::cfg_words_t        cfg_o
);

  acfe_pkg::cfg_words_t cfg_q;
  acfe_pkg::cfg_words_t cfg_d;
  logic                 wr_en;
  logic [2:0]           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        acfe_pkg::REG_MODE:        cfg_d.mode        = pwdata;
        acfe_pkg::REG_RESERVED:    cfg_d.reserved    = pwdata;
        acfe_pkg::REG_ROTATION:    cfg_d.rotation    = pwdata;
        acfe_pkg::REG_SUCTION:     cfg_d.suction     = pwdata;
        acfe_pkg::REG_MOTION_KIND: cfg_d.motion_kind = pwdata;
        acfe_pkg::REG_GRIPPER:     cfg_d.gripper     = pwdata;
        acfe_pkg::REG_PAUSE:       cfg_d.pause       = pwdata;
        default:                   cfg_d             = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      acfe_pkg::REG_MODE:        prdata = cfg_q.mode;
      acfe_pkg::REG_RESERVED:    prdata = cfg_q.reserved;
      acfe_pkg::REG_ROTATION:    prdata = cfg_q.rotation;
      acfe_pkg::REG_SUCTION:     prdata = cfg_q.suction;
      acfe_pkg::REG_MOTION_KIND: prdata = cfg_q.motion_kind;
      acfe_pkg::REG_GRIPPER:     prdata = cfg_q.gripper;
      acfe_pkg::REG_PAUSE:       prdata = cfg_q.pause;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {acfe_pkg::ModeReset, 32'h0, 32'h0, 32'h0,
                acfe_pkg::MotionKindReset, 32'h0, 32'h0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/acfe_serializer.sv
// ----------------------------------------------------------------------------
// acfe_serializer
// Merges lane words and register words into the 42-byte frame, one byte a beat.
// ----------------------------------------------------------------------------
module acfe_serializer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pend_vld_i,
  input  acfe_pkg::coord_words_t      coords_i,
  input  acfe_pkg::cfg_words_t        cfg_i,
  output logic                        load_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // frame_byte
  output logic                        m_axis_tlast   // last_byte
);

  logic                        busy_q, busy_d;
  logic [acfe_pkg::IdxW-1:0]   idx_q, idx_d;
  acfe_pkg::coord_words_t      frame_q;
  logic [acfe_pkg::IdxW-1:0]   off;
  logic [3:0]                  wsel;
  logic [1:0]                  ksel;
  logic [acfe_pkg::WordW-1:0]  word;
  logic [7:0]                  body_byte;
  logic                        last;
  logic                        fire;

  assign last   = (idx_q == acfe_pkg::LastIdx);
  assign fire   = busy_q & m_axis_tready;
  assign load_o = pend_vld_i & (~busy_q | (fire & last));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (fire) begin
      if (last) begin
        busy_d = load_o;
        idx_d  = '0;
      end else begin
        idx_d  = idx_q + 1'b1;
      end
    end else if (load_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      frame_q <= coords_i;
    end
  end

  assign off  = idx_q - 1'b1;
  assign wsel = off[5:2];
  assign ksel = off[1:0];

  always_comb begin
    unique case (wsel)
      4'd0:    word = cfg_i.mode;
      4'd1:    word = cfg_i.reserved;
      4'd2:    word = frame_q.x;
      4'd3:    word = frame_q.y;
      4'd4:    word = frame_q.z;
      4'd5:    word = cfg_i.rotation;
      4'd6:    word = cfg_i.suction;
      4'd7:    word = cfg_i.motion_kind;
      4'd8:    word = cfg_i.gripper;
      4'd9:    word = cfg_i.pause;
      default: word = '0;
    endcase
    unique case (ksel)
      2'd0:    body_byte = word[7:0];
      2'd1:    body_byte = word[15:8];
      2'd2:    body_byte = word[23:16];
      default: body_byte = word[31:24];
    endcase
  end

  always_comb begin
    priority if (idx_q == '0) begin
      m_axis_tdata = acfe_pkg::StartByte;
    end else if (last) begin
      m_axis_tdata = acfe_pkg::EndByte;
    end else begin
      m_axis_tdata = body_byte;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = last;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= acfe_pkg::LastIdx)
    else $error("byte index beyond frame end");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last |=> busy_q && idx_q == $past(idx_q) + 1'b1)
    else $error("byte index did not advance");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> idx_q == '0)
    else $error("idle with nonzero byte index");

endmodule

>>> sv/arm_command_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// arm_command_frame_encoder_top
// Converts a three-coordinate target into a 42-byte arm command frame.
// ----------------------------------------------------------------------------
// Input channel s_axis: one item carries x, y and z as signed 24-bit integers.
// Output channel m_axis: 42 items per input, one frame byte each: 0xA5, ten
// single-precision words least significant byte first, then 0x5A with tlast.
// Words 3..5 are the converted coordinates; the others come from the APB
// registers at byte addresses 0x00..0x18.
// Three lanes convert the coordinates into a registered holding stage; the
// serializer then takes the held words and sends one byte per cycle while
// m_axis_tready is high.
// Overlap: the next input is taken while the current frame is still going
// out, and frames follow each other without a gap.
// Reset: no frame in flight, registers at their defaults (mode 3.0, motion
// kind 1.0, the rest 0.0).
// Stall: a low m_axis_tready holds the current byte; once the holding stage
// is full, s_axis_tready drops until the running frame ends.
// ----------------------------------------------------------------------------
module arm_command_frame_encoder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [71:0]                s_axis_tdata,  // x_coord, y_coord, z_coord
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // frame_byte
  output logic                       m_axis_tlast,  // last_byte
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [acfe_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic                   pend_q, pend_d;
  logic                   take;
  logic                   load;
  acfe_pkg::coord_words_t coords;
  acfe_pkg::cfg_words_t   cfg;

  assign s_axis_tready = ~pend_q | load;
  assign take          = s_axis_tvalid & s_axis_tready;

  always_comb begin
    pend_d = pend_q;
    if (take) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  acfe_lane u_lane_x (
    .clk_i  (clk_i),
    .load_i (take),
    .coord_i(s_axis_tdata[23:0]),
    .word_o (coords.x)
  );

  acfe_lane u_lane_y (
    .clk_i  (clk_i),
    .load_i (take),
    .coord_i(s_axis_tdata[47:24]),
    .word_o (coords.y)
  );

  acfe_lane u_lane_z (
    .clk_i  (clk_i),
    .load_i (take),
    .coord_i(s_axis_tdata[71:48]),
    .word_o (coords.z)
  );

  acfe_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  acfe_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pend_vld_i   (pend_q),
    .coords_i     (coords),
    .cfg_i        (cfg),
    .load_o       (load),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

>>> sim/arm_command_frame_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_command_frame_encoder_top_tb
// Checks the frame bytes produced for each coordinate item against a local
// encoder model: integer to single conversion of x, y and z, register words,
// start and end bytes. Covers directed edge values, every register at several
// settings, and random coordinates with random stalls on both streams.
// ----------------------------------------------------------------------------
module arm_command_frame_encoder_top_tb;
  import acfe_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  localparam logic [AddrW-1:0] UnmappedAddr = AddrW'(28);

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [71:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic [WordW-1:0]  cfg_shadow [7];
  frame_byte_t       expected_bytes_q [$];
  int unsigned       mismatch_cnt = 0;
  int unsigned       bytes_seen = 0;
  bit                send_idle = 1'b0;
  bit                recv_idle = 1'b0;

  arm_command_frame_encoder_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [WordW-1:0] coord_to_float(input logic [CoordW-1:0] coord);
    logic [CoordW-1:0] mag;
    logic [22:0]       frac;
    int                msb;
    mag = coord[CoordW-1] ? (~coord + 1'b1) : coord;
    if (mag > MagLimit) begin
      mag = MagLimit;
    end
    if (mag == '0) begin
      return '0;
    end
    msb = 22;
    while (!mag[msb]) begin
      msb--;
    end
    frac = 23'({8'd0, mag} << (23 - msb));
    return {coord[CoordW-1], ExpBias + 8'(msb), frac};
  endfunction

  function automatic void predict_frame(input logic [CoordW-1:0] x, y, z);
    logic [WordW-1:0] words [10];
    words = '{cfg_shadow[REG_MODE], cfg_shadow[REG_RESERVED],
              coord_to_float(x), coord_to_float(y), coord_to_float(z),
              cfg_shadow[REG_ROTATION], cfg_shadow[REG_SUCTION],
              cfg_shadow[REG_MOTION_KIND], cfg_shadow[REG_GRIPPER],
              cfg_shadow[REG_PAUSE]};
    expected_bytes_q.push_back('{StartByte, 1'b0});
    foreach (words[w]) begin
      for (int k = 0; k < 4; k++) begin
        expected_bytes_q.push_back('{words[w][8*k +: 8], 1'b0});
      end
    end
    expected_bytes_q.push_back('{EndByte, 1'b1});
  endfunction

  // Check each accepted frame byte against the oldest expected one.
  always @(posedge clk_i) begin
    frame_byte_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected byte %h last %b at %0t", m_axis_tdata, m_axis_tlast, $time);
        end
      end else begin
        exp_b = expected_bytes_q.pop_front();
        if (exp_b.data !== m_axis_tdata || exp_b.last !== m_axis_tlast) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("byte %0d: expected data %h last %b, got data %h last %b",
                     bytes_seen, exp_b.data, exp_b.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
      bytes_seen++;
    end
  end

  // Frame sink with random stall bursts.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (recv_idle && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_coords(input logic [CoordW-1:0] x, y, z);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame(x, y, z);
  endtask

  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [31:0] data);
    apb_write(AddrW'(4 * idx), data);
    cfg_shadow[idx] = data;
  endtask

  task automatic cfg_write_all(input logic [31:0] base, input bit pick_random);
    cfg_idx_e idx;
    idx = idx.first();
    do begin
      cfg_write(idx, pick_random ? $urandom() : base);
      idx = idx.next();
    end while (idx != idx.first());
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    logic [CoordW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = CoordW'($urandom());
      1: v = CoordW'($urandom_range(0, 255));
      2: v = CoordW'(1) << $urandom_range(0, 23);
      3: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = 24'h7FFFFF;
          2: v = 24'h800001;
          default: v = 24'h800000;
        endcase
      end
      default: v = CoordW'($urandom()) >> $urandom_range(0, 23);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = ~v + 1'b1;
    end
    return v;
  endfunction

  task automatic test_edge_coords();
    send_coords(24'h000000, 24'h000000, 24'h000000);
    send_coords(24'h000001, 24'hFFFFFF, 24'h000002);
    send_coords(24'h7FFFFF, 24'h800001, 24'h800000);
    send_coords(24'h800000, 24'h7FFFFF, 24'h000000);
    send_coords(24'h400000, 24'hC00000, 24'h000003);
    send_coords(24'h555555, 24'hAAAAAA, 24'h7FFFFE);
    send_coords(24'h0000FF, 24'hFFFF01, 24'h001000);
    send_coords(24'h3FFFFF, 24'hC00001, 24'h123456);
  endtask

  task automatic test_register_settings();
    drain_frames();
    cfg_write_all(32'h0000_0000, 1'b0);
    send_coords(24'h000005, 24'hFFFFFB, 24'h000000);
    send_coords(24'h7FFFFF, 24'h800000, 24'h000001);
    drain_frames();
    cfg_write_all(32'hFFFF_FFFF, 1'b0);
    send_coords(24'h000000, 24'h100000, 24'hF00000);
    send_coords(24'h00000A, 24'hFFFFF6, 24'h7FFFFF);
    drain_frames();
    cfg_write(REG_MODE, 32'hA5A5_5A5A);
    cfg_write(REG_PAUSE, 32'h5A5A_A5A5);
    apb_write(UnmappedAddr, 32'hDEAD_BEEF);
    send_coords(24'h000001, 24'h000002, 24'h000004);
    drain_frames();
    cfg_write_all(32'h0, 1'b1);
    send_coords(24'h00FFFF, 24'hFF0001, 24'h0F0F0F);
    send_coords(24'h800000, 24'h800000, 24'h800000);
  endtask

  task automatic test_random_coords();
    for (int i = 0; i < 250; i++) begin
      if (i % 60 == 59) begin
        drain_frames();
        case ($urandom_range(0, 3))
          0: cfg_write_all(32'h0000_0000, 1'b0);
          1: cfg_write_all(32'hFFFF_FFFF, 1'b0);
          default: cfg_write_all(32'h0, 1'b1);
        endcase
      end
      if (i == 200) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else if (i < 200 && i % 40 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      send_coords(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    cfg_shadow[REG_MODE]        = ModeReset;
    cfg_shadow[REG_RESERVED]    = '0;
    cfg_shadow[REG_ROTATION]    = '0;
    cfg_shadow[REG_SUCTION]     = '0;
    cfg_shadow[REG_MOTION_KIND] = MotionKindReset;
    cfg_shadow[REG_GRIPPER]     = '0;
    cfg_shadow[REG_PAUSE]       = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_edge_coords();
    test_register_settings();
    test_random_coords();
    drain_frames();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_bytes_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
